// ===== src/arx_feistel_tag_defines.svh =====
// assertion macros for the arx feistel tag block
`ifndef ARX_FEISTEL_TAG_DEFINES_SVH
`define ARX_FEISTEL_TAG_DEFINES_SVH

// same-cycle implication, checked out of reset
`define AFT_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("aft assertion failed");

// next-cycle implication, checked out of reset
`define AFT_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("aft assertion failed");

`endif

// ===== src/aft_pkg.sv =====
// shared types, constants and helpers for the arx feistel tag block
package aft_pkg;

    localparam int WORD_W        = 32;
    localparam int TAG_W         = 16;
    localparam int SCHED_W       = 59;
    localparam int ROUNDS_DEFAULT = 59;
    localparam int CFG_IDX_W     = 3;
    localparam int ROT_OPEN      = 7;
    localparam int ROT_CLOSE     = 11;

    localparam logic [SCHED_W-1:0] SCHED_RESET = 59'h0AD5A6B4D2E1F0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_KEY_WORD_0     = 3'd0,
        REG_KEY_WORD_1     = 3'd1,
        REG_KEY_WORD_2     = 3'd2,
        REG_KEY_WORD_3     = 3'd3,
        REG_ROUND_SCHEDULE = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [WORD_W-1:0] s3;
        logic [WORD_W-1:0] s2;
        logic [WORD_W-1:0] s1;
        logic [WORD_W-1:0] s0;
    } aft_state_t;

    function automatic logic [WORD_W-1:0] rotl_open(input logic [WORD_W-1:0] x);
        rotl_open = {x[WORD_W-1-ROT_OPEN:0], x[WORD_W-1:WORD_W-ROT_OPEN]};
    endfunction

    function automatic logic [WORD_W-1:0] rotl_close(input logic [WORD_W-1:0] x);
        rotl_close = {x[WORD_W-1-ROT_CLOSE:0], x[WORD_W-1:WORD_W-ROT_CLOSE]};
    endfunction

endpackage

// ===== src/aft_round.sv =====
// one registered feistel round stage
module aft_round
    import aft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       en,
    input  logic       open_sel,
    input  logic       in_valid,
    input  aft_state_t in_state,
    output logic       out_valid,
    output aft_state_t out_state
);

    logic              valid_reg;
    aft_state_t        state_reg;
    aft_state_t        state_next;
    logic [WORD_W-1:0] sum;
    logic [WORD_W-1:0] mix;

    always_comb
    begin
        if (open_sel)
        begin
            sum = in_state.s1 + in_state.s2;
            mix = rotl_open(sum);
        end
        else
        begin
            sum = in_state.s2 + in_state.s3;
            mix = rotl_close(sum);
        end
        state_next.s0 = in_state.s1;
        state_next.s1 = in_state.s2;
        state_next.s2 = in_state.s3;
        state_next.s3 = in_state.s0 ^ mix;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            state_reg <= state_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_state = state_reg;

endmodule

// ===== src/arx_feistel_tag.sv =====
// top level of the arx feistel tag block
// Keyed 16-bit tag over a 128-bit message: the four message words are xored with the key,
// run through ROUNDS arx feistel rounds (type of round j from bit j of round_schedule) and
// the low half of the final first word xor key word 0 is returned. One register stage per
// round plus a key-mix stage and an output stage, and one message is accepted every cycle
// while the output buffer has room. The pipeline stalls as a whole only when the two-entry
// output buffer is full; s_axis_tready comes straight from a register. Configuration must
// only be written while no message is in flight.
module arx_feistel_tag
    import aft_pkg::*;
#(
    parameter int ROUNDS = ROUNDS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [4*WORD_W-1:0]   s_axis_tdata,   // msg_word_0, msg_word_1, msg_word_2, msg_word_3
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [TAG_W-1:0]      m_axis_tdata,   // tag
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [SCHED_W-1:0]    cfg_data
);

    `include "arx_feistel_tag_defines.svh"

    logic [WORD_W-1:0]  key0_reg, key1_reg, key2_reg, key3_reg;
    logic [SCHED_W-1:0] sched_reg;

    logic               en;
    logic               valid_pipe [0:ROUNDS];
    aft_state_t         state_pipe [0:ROUNDS];

    logic               in_valid_reg;
    aft_state_t         in_state_reg;
    aft_state_t         in_state_next;

    logic               out_valid_reg, skid_valid_reg;
    logic [TAG_W-1:0]   out_tag_reg, skid_tag_reg;
    logic [TAG_W-1:0]   tag_next;
    logic               arrive;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key0_reg  <= '0;
            key1_reg  <= '0;
            key2_reg  <= '0;
            key3_reg  <= '0;
            sched_reg <= SCHED_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_KEY_WORD_0:     key0_reg  <= cfg_data[WORD_W-1:0];
                REG_KEY_WORD_1:     key1_reg  <= cfg_data[WORD_W-1:0];
                REG_KEY_WORD_2:     key2_reg  <= cfg_data[WORD_W-1:0];
                REG_KEY_WORD_3:     key3_reg  <= cfg_data[WORD_W-1:0];
                REG_ROUND_SCHEDULE: sched_reg <= cfg_data;
                default:            ;
            endcase
        end
    end

    // whole pipeline moves unless the output buffer is full
    assign en            = !skid_valid_reg;
    assign s_axis_tready = en;

    always_comb
    begin
        in_state_next.s0 = s_axis_tdata[WORD_W-1:0]          ^ key0_reg;
        in_state_next.s1 = s_axis_tdata[2*WORD_W-1:WORD_W]   ^ key1_reg;
        in_state_next.s2 = s_axis_tdata[3*WORD_W-1:2*WORD_W] ^ key2_reg;
        in_state_next.s3 = s_axis_tdata[4*WORD_W-1:3*WORD_W] ^ key3_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            in_state_reg <= in_state_next;
        end
    end

    assign valid_pipe[0] = in_valid_reg;
    assign state_pipe[0] = in_state_reg;

    for (genvar j = 0; j < ROUNDS; j++)
    begin : g_round
        aft_round u_round (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .open_sel  (sched_reg[j]),
            .in_valid  (valid_pipe[j]),
            .in_state  (state_pipe[j]),
            .out_valid (valid_pipe[j+1]),
            .out_state (state_pipe[j+1])
        );
    end

    assign tag_next = state_pipe[ROUNDS].s0[TAG_W-1:0] ^ key0_reg[TAG_W-1:0];
    assign arrive   = en && valid_pipe[ROUNDS];

    // output register with skid entry
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (skid_valid_reg)
            begin
                if (m_axis_tready)
                begin
                    skid_valid_reg <= 1'b0;
                end
            end
            else if (arrive && out_valid_reg && !m_axis_tready)
            begin
                skid_valid_reg <= 1'b1;
            end
            else if (!out_valid_reg || m_axis_tready)
            begin
                out_valid_reg <= arrive;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (skid_valid_reg)
        begin
            if (m_axis_tready)
            begin
                out_tag_reg <= skid_tag_reg;
            end
        end
        else if (arrive && out_valid_reg && !m_axis_tready)
        begin
            skid_tag_reg <= tag_next;
        end
        else if (!out_valid_reg || m_axis_tready)
        begin
            out_tag_reg <= tag_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_tag_reg;

    `AFT_ASSERT_NOW(a_skid_behind_out, skid_valid_reg, out_valid_reg)
    `AFT_ASSERT_NEXT(a_stalled_beat_to_skid,
        arrive && out_valid_reg && !m_axis_tready, skid_valid_reg && out_valid_reg)
    `AFT_ASSERT_NEXT(a_skid_drains, skid_valid_reg && m_axis_tready,
        !skid_valid_reg && out_valid_reg)

endmodule

// ===== bench/arx_feistel_tag_test.sv =====
// self-checking testbench for the arx feistel tag block
`timescale 1ns / 100ps

module arx_feistel_tag_test;
    import aft_pkg::*;

    localparam int HALF_PERIOD   = 5;
    localparam int RESET_CYCLES  = 5;
    localparam int SEGMENTS      = 8;
    localparam int SEGMENT_BEATS = 200;
    localparam int HOLD_CYCLES   = 300;
    localparam int QUIET_LIMIT   = 5000;
    localparam int DRAIN_CYCLES  = ROUNDS_DEFAULT + 8;
    localparam int MSG_W         = 4 * WORD_W;

    // indexes past the last register, writes there must be dropped
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = CFG_IDX_W'(REG_ROUND_SCHEDULE + 1);
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = '1;

    typedef enum bit {ROW_BEAT, ROW_WRITE} row_kind_t;

    typedef struct {
        row_kind_t            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [MSG_W-1:0]     value;
        bit                   pinned;
        logic [TAG_W-1:0]     tag;
    } plan_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [MSG_W-1:0]     s_axis_tdata;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [TAG_W-1:0]     m_axis_tdata;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [SCHED_W-1:0]   cfg_data;

    // shadow of the block's registers
    logic [WORD_W-1:0]    key_copy [4];
    logic [SCHED_W-1:0]   sched_copy;

    logic [TAG_W-1:0]     pending_tags [$];
    plan_row_t            plan [$];
    int                   mismatch_count = 0;
    int                   quiet_cycles = 0;
    int                   tx_idle_pct = 0;
    int                   rx_idle_pct = 0;
    bit                   hold_request = 1'b0;
    bit                   hold_started = 1'b0;
    int                   hold_left = 0;

    arx_feistel_tag #(
        .ROUNDS (ROUNDS_DEFAULT)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always #HALF_PERIOD clk = ~clk;

    function automatic logic [TAG_W-1:0] predict_tag(input logic [MSG_W-1:0] msg);
        logic [WORD_W-1:0] w0;
        logic [WORD_W-1:0] w1;
        logic [WORD_W-1:0] w2;
        logic [WORD_W-1:0] w3;
        logic [WORD_W-1:0] mix;
        logic [WORD_W-1:0] fresh;
        w0 = msg[0*WORD_W +: WORD_W] ^ key_copy[0];
        w1 = msg[1*WORD_W +: WORD_W] ^ key_copy[1];
        w2 = msg[2*WORD_W +: WORD_W] ^ key_copy[2];
        w3 = msg[3*WORD_W +: WORD_W] ^ key_copy[3];
        for (int r = 0; r < ROUNDS_DEFAULT; r++)
        begin
            // schedule bits past the register width count as close rounds
            if (r < SCHED_W && sched_copy[r])
            begin
                mix   = w1 + w2;
                fresh = w0 ^ ((mix << ROT_OPEN) | (mix >> (WORD_W - ROT_OPEN)));
            end
            else
            begin
                mix   = w2 + w3;
                fresh = w0 ^ ((mix << ROT_CLOSE) | (mix >> (WORD_W - ROT_CLOSE)));
            end
            w0 = w1;
            w1 = w2;
            w2 = w3;
            w3 = fresh;
        end
        return TAG_W'(w0 ^ key_copy[0]);
    endfunction

    function automatic plan_row_t beat_row(input logic [MSG_W-1:0] msg, input bit pinned = 1'b0,
                                           input logic [TAG_W-1:0] tag = '0);
        plan_row_t row;
        row.kind   = ROW_BEAT;
        row.index  = '0;
        row.value  = msg;
        row.pinned = pinned;
        row.tag    = tag;
        return row;
    endfunction

    function automatic plan_row_t write_row(input logic [CFG_IDX_W-1:0] index,
                                            input logic [MSG_W-1:0] value);
        plan_row_t row;
        row.kind   = ROW_WRITE;
        row.index  = index;
        row.value  = value;
        row.pinned = 1'b0;
        row.tag    = '0;
        return row;
    endfunction

    // called at a falling edge, returns at a falling edge
    task automatic send_tag(input logic [MSG_W-1:0] msg, input bit pinned,
                            input logic [TAG_W-1:0] pinned_tag);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= msg;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        pending_tags.push_back(pinned ? pinned_tag : predict_tag(msg));
        @(negedge clk);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_tags.size() != 0)
            @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [SCHED_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= index;
        cfg_data  <= value;
        case (index)
            REG_KEY_WORD_0:     key_copy[0] = value[WORD_W-1:0];
            REG_KEY_WORD_1:     key_copy[1] = value[WORD_W-1:0];
            REG_KEY_WORD_2:     key_copy[2] = value[WORD_W-1:0];
            REG_KEY_WORD_3:     key_copy[3] = value[WORD_W-1:0];
            REG_ROUND_SCHEDULE: sched_copy  = value;
            default:            ;
        endcase
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // result side: random stalls, plus one long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request && !hold_started)
        begin
            hold_started = 1'b1;
            hold_left    = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            m_axis_tready <= 1'b0;
            hold_left = hold_left - 1;
        end
        else
            m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (pending_tags.size() == 0)
            begin
                $error("tag: expected none, actual %h", m_axis_tdata);
                mismatch_count++;
            end
            else
            begin
                if (m_axis_tdata !== pending_tags[0])
                begin
                    $error("tag: expected %h, actual %h", pending_tags[0], m_axis_tdata);
                    mismatch_count++;
                end
                void'(pending_tags.pop_front());
            end
        end
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        logic [MSG_W-1:0]  msg;
        logic [WORD_W-1:0] word;
        logic [63:0]       wide;

        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        for (int w = 0; w < 4; w++)
            key_copy[w] = '0;
        sched_copy = SCHED_RESET;

        // zero key and zero message keep every state word at zero
        plan.push_back(beat_row('0, 1'b1, 16'h0000));
        plan.push_back(beat_row('1));
        plan.push_back(beat_row({4{32'hAAAA_AAAA}}));
        plan.push_back(beat_row({4{32'h5555_5555}}));
        plan.push_back(beat_row({32'h8000_0000, 32'h0000_0001, 32'h8000_0000, 32'h0000_0001}));
        plan.push_back(beat_row({32'h0000_0001, 32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF}));
        // keys written with bits above their width, which must be dropped
        plan.push_back(write_row(REG_KEY_WORD_0, '1));
        plan.push_back(write_row(REG_KEY_WORD_1, '1));
        plan.push_back(write_row(REG_KEY_WORD_2, '1));
        plan.push_back(write_row(REG_KEY_WORD_3, '1));
        plan.push_back(write_row(REG_ROUND_SCHEDULE, '0));
        // message equal to key clears the state, tag is then key word 0
        plan.push_back(beat_row('1, 1'b1, 16'hFFFF));
        plan.push_back(beat_row('0));
        plan.push_back(beat_row({32'h0000_FFFF, 32'hFFFF_0000, 32'h1234_5678, 32'h9ABC_DEF0}));
        plan.push_back(write_row(REG_SPARE_FIRST, '0));
        plan.push_back(write_row(CFG_IDX_W'(REG_SPARE_FIRST + 1), '0));
        plan.push_back(write_row(REG_SPARE_LAST, '0));
        plan.push_back(beat_row('1, 1'b1, 16'hFFFF));
        plan.push_back(write_row(REG_ROUND_SCHEDULE, '1));
        plan.push_back(beat_row('1, 1'b1, 16'hFFFF));
        plan.push_back(beat_row({32'h0123_4567, 32'h89AB_CDEF, 32'hFEDC_BA98, 32'h7654_3210}));
        plan.push_back(beat_row({32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000}));
        plan.push_back(write_row(REG_KEY_WORD_0, '0));
        plan.push_back(write_row(REG_KEY_WORD_1, '0));
        plan.push_back(write_row(REG_KEY_WORD_2, '0));
        plan.push_back(write_row(REG_KEY_WORD_3, '0));
        plan.push_back(write_row(REG_ROUND_SCHEDULE, MSG_W'(SCHED_RESET)));
        plan.push_back(beat_row('0, 1'b1, 16'h0000));
        plan.push_back(beat_row({32'hDEAD_BEEF, 32'hCAFE_F00D, 32'h0BAD_C0DE, 32'hFACE_B00C}));

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_WRITE)
            begin
                wait_drained();
                write_reg(plan[i].index, plan[i].value[SCHED_W-1:0]);
            end
            else
                send_tag(plan[i].value, plan[i].pinned, plan[i].tag);
        end

        for (int seg = 0; seg < SEGMENTS; seg++)
        begin
            wait_drained();
            for (int r = REG_KEY_WORD_0; r <= REG_ROUND_SCHEDULE; r++)
            begin
                wide = {$urandom, $urandom};
                if (seg == 1)
                    wide = '0;
                else if (seg == 2)
                    wide = '1;
                write_reg(CFG_IDX_W'(r), wide[SCHED_W-1:0]);
            end
            wide = {$urandom, $urandom};
            write_reg(CFG_IDX_W'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
                      wide[SCHED_W-1:0]);

            if (seg < 3)
            begin
                tx_idle_pct = 34;
                rx_idle_pct = 79;
            end
            else if (seg < 6)
            begin
                tx_idle_pct = 79;
                rx_idle_pct = 34;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            // long output hold-off while beats keep coming, fills the pipeline
            if (seg == 6)
                hold_request = 1'b1;

            for (int beat = 0; beat < SEGMENT_BEATS; beat++)
            begin
                if (seg == 4 && beat == SEGMENT_BEATS / 2)
                    wait_drained();
                for (int w = 0; w < 4; w++)
                begin
                    case ($urandom_range(9))
                        0:       word = '0;
                        1:       word = '1;
                        2:       word = key_copy[w];
                        default: word = $urandom;
                    endcase
                    msg[w*WORD_W +: WORD_W] = word;
                end
                send_tag(msg, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_tags.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/aft_pkg.sv
src/aft_round.sv
src/arx_feistel_tag.sv
bench/arx_feistel_tag_test.sv
